@@ design/tcma_pkg.sv @@
// ----------------------------------------------------------------------------
// tcma_pkg
// shared constants and types of the three channel centred moving average
// ----------------------------------------------------------------------------
package tcma_pkg;

   localparam int MAX_WINDOW_DEFAULT  = 63;
   localparam int SAMPLE_W            = 32;
   localparam int EPOCH_W             = 20;
   localparam int WINDOW_LENGTH_W     = 6;
   localparam int WINDOW_LENGTH_RESET = 21;
   localparam int LANE_COUNT          = 3;
   localparam int REQ_DATA_W          = 120;
   localparam int RSP_DATA_W          = 120;

   typedef struct packed {
      logic clear;
      logic update;
      logic subtract;
      logic start;
   } lane_ctl_type;

endpackage

@@ design/tcma_ring.sv @@
// ----------------------------------------------------------------------------
// tcma_ring
// sample history memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tcma_ring #(
   parameter int DEPTH  = 63,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 96
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tcma_lane.sv @@
// ----------------------------------------------------------------------------
// tcma_lane
// one channel: running window sum and a radix-2 restoring divider that
// turns the sum into the truncated average
// ----------------------------------------------------------------------------
module tcma_lane #(
   parameter int CNT_W = 6,
   parameter int SUM_W = 38
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tcma_pkg::lane_ctl_type         ctl,
   input  logic [tcma_pkg::SAMPLE_W-1:0]  new_sample,
   input  logic [tcma_pkg::SAMPLE_W-1:0]  old_sample,
   input  logic [CNT_W-1:0]               divisor,
   output logic [tcma_pkg::SAMPLE_W-1:0]  average,
   output logic                           done
);

   import tcma_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] new_ext;
   logic signed [SUM_W-1:0] old_ext;

   logic              busy_ff;
   logic              done_ff;
   logic              neg_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W-1:0]  div_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  rem_in;
   logic [SUM_W-1:0]  quo_ff;
   logic [SUM_W-1:0]  quo_in;
   logic [CNT_W:0]    shifted;
   logic [CNT_W:0]    diff;
   logic              ge;
   logic [SUM_W-1:0]  magnitude;
   logic [SUM_W-1:0]  signed_quo;
   logic [SAMPLE_W-1:0] average_ff;

   assign new_ext = SUM_W'(signed'(new_sample));
   assign old_ext = SUM_W'(signed'(old_sample));

   always_comb begin
      sum_in = sum_ff + new_ext;
      if (ctl.subtract) begin
         sum_in = sum_in - old_ext;
      end
   end

   assign magnitude = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign ge      = (shifted >= {1'b0, div_ff});
   assign rem_in  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
   assign quo_in  = {quo_ff[SUM_W-2:0], ge};

   assign signed_quo = neg_ff ? (~quo_in + SUM_W'(1)) : quo_in;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         sum_ff <= '0;
      end else if (ctl.update) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && !ctl.start && (step_ff == STEP_W'(SUM_W - 1));
         if (ctl.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         neg_ff <= sum_ff[SUM_W-1];
         div_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= magnitude;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            average_ff <= signed_quo[SAMPLE_W-1:0];
         end
      end
   end

   assign average = average_ff;
   assign done    = done_ff;

endmodule

@@ design/three_channel_centred_moving_average.sv @@
// ----------------------------------------------------------------------------
// three_channel_centred_moving_average
// centred boxcar average of mean, minimum and maximum fitness per epoch
// ----------------------------------------------------------------------------
// req_ carries one transaction per epoch: epoch and three signed Q16.16
// samples. rsp_ returns the centred epoch and the three window averages,
// truncated toward zero, once the epoch reaches half the window.
// csr_ writes window_length; an even value uses the next lower odd size, and
// every write empties the window. Write it only while the block is idle.
// A request goes through one memory read, one sum update, one divider start,
// a divide in which the three lane dividers produce one quotient bit per cycle
// in parallel, and the load of the rsp_ output register; the next request is
// taken only once the block is back in idle after that load.
// A sample too early to average returns the block to idle after the sum update.
// A finished result sits in the rsp_ output register; the next request is
// accepted meanwhile, and its result waits until the receiver takes the
// previous one, so a stalled receiver eventually stalls req_tready.
// Reset is synchronous: window length returns to 21 and the window is empty.
// ----------------------------------------------------------------------------
module three_channel_centred_moving_average #(
   parameter int MAX_WINDOW = tcma_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // epoch, mean_sample, minimum_sample, maximum_sample, zero fill
   input  logic [tcma_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // centre_epoch, mean_average, minimum_average, maximum_average, zero fill
   output logic [tcma_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tcma_pkg::WINDOW_LENGTH_W-1:0] csr_data
);

   import tcma_pkg::*;

   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int WIN_W  = (CNT_W > WINDOW_LENGTH_W) ? CNT_W : WINDOW_LENGTH_W;
   localparam int CAP    = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
   localparam int RING_W = LANE_COUNT * SAMPLE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_START,
      S_DIV,
      S_OUT
   } state_type;

   state_type state_ff;

   logic [WINDOW_LENGTH_W-1:0] window_length_ff;
   logic [CNT_W-1:0]           wp_ff;
   logic [CNT_W-1:0]           fill_ff;
   logic [EPOCH_W-1:0]         epoch_ff;
   logic [RING_W-1:0]          samples_ff;
   logic                       rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]      rsp_tdata_ff;

   logic [WIN_W-1:0]  wl_ext;
   logic [WIN_W-1:0]  w_odd;
   logic [CNT_W-1:0]  w_eff;
   logic [CNT_W-1:0]  half;
   logic              full;
   logic              req_fire;
   logic              csr_fire;
   logic              emit;
   logic [RING_W-1:0] ring_rd_data;
   lane_ctl_type      lane_ctl;
   logic [SAMPLE_W-1:0] lane_avg [LANE_COUNT];
   logic [LANE_COUNT-1:0] lane_done;

   assign wl_ext = WIN_W'(window_length_ff);

   always_comb begin
      if (wl_ext == '0) begin
         w_odd = WIN_W'(1);
      end else if (!wl_ext[0]) begin
         w_odd = wl_ext - WIN_W'(1);
      end else begin
         w_odd = wl_ext;
      end
      if (w_odd > WIN_W'(CAP)) begin
         w_odd = WIN_W'(CAP);
      end
   end

   assign w_eff = w_odd[CNT_W-1:0];
   assign half  = w_eff >> 1;
   assign full  = (fill_ff == w_eff);
   assign emit  = (epoch_ff >= EPOCH_W'(half));

   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;

   always_comb begin
      lane_ctl          = '0;
      lane_ctl.clear    = csr_fire;
      lane_ctl.update   = (state_ff == S_READ);
      lane_ctl.subtract = full;
      lane_ctl.start    = (state_ff == S_START);
   end

   tcma_ring #(
      .DEPTH  (MAX_WINDOW),
      .ADDR_W (CNT_W),
      .DATA_W (RING_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == S_READ),
      .wr_addr (wp_ff),
      .wr_data (samples_ff),
      .rd_en   (req_fire),
      .rd_addr (wp_ff),
      .rd_data (ring_rd_data)
   );

   for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
      tcma_lane #(
         .CNT_W (CNT_W),
         .SUM_W (SUM_W)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (lane_ctl),
         .new_sample (samples_ff[g*SAMPLE_W +: SAMPLE_W]),
         .old_sample (ring_rd_data[g*SAMPLE_W +: SAMPLE_W]),
         .divisor    (fill_ff),
         .average    (lane_avg[g]),
         .done       (lane_done[g])
      );
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         epoch_ff   <= req_tdata[EPOCH_W-1:0];
         samples_ff <= req_tdata[EPOCH_W +: RING_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         window_length_ff <= WINDOW_LENGTH_W'(WINDOW_LENGTH_RESET);
         wp_ff            <= '0;
         fill_ff          <= '0;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (csr_fire) begin
                  window_length_ff <= csr_data;
                  wp_ff            <= '0;
                  fill_ff          <= '0;
               end else if (req_fire) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               if (!full) begin
                  fill_ff <= fill_ff + CNT_W'(1);
               end
               wp_ff    <= (wp_ff + CNT_W'(1) == w_eff) ? '0 : wp_ff + CNT_W'(1);
               state_ff <= emit ? S_START : S_IDLE;
            end
            S_START: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (&lane_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= RSP_DATA_W'({lane_avg[2], lane_avg[1], lane_avg[0],
                                                epoch_ff - EPOCH_W'(half)});
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
